>>> design/base62_id_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// base62_id_encoder_top_defines.svh
// Assertion macros used by the base-62 encoder controller.
// ----------------------------------------------------------------------------
`ifndef BASE62_ID_ENCODER_TOP_DEFINES_SVH
`define BASE62_ID_ENCODER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define B62_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define B62_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/b62enc_pkg.sv
// ----------------------------------------------------------------------------
// b62enc_pkg
// Types, constants and the digit-to-character map of the base-62 encoder.
// ----------------------------------------------------------------------------
package b62enc_pkg;

	localparam int CHUNK_BITS = 21;
	localparam int DIG_W      = 6;
	localparam int X_W        = DIG_W + CHUNK_BITS;
	localparam int RECIP_W    = 28;
	localparam int DIV_SHIFT  = 33;
	// ceil(2^33 / 62); exact quotient for every x below 62 * 2^21
	localparam logic [RECIP_W-1:0] RECIP = 28'd138547333;

	localparam logic [DIG_W-1:0] UPPER_START = 6'd26;
	localparam logic [DIG_W-1:0] DIGIT_START = 6'd52;
	localparam logic [6:0]       CH_LOWER    = 7'd97;
	localparam logic [6:0]       CH_UPPER    = 7'd65;
	localparam logic [6:0]       CH_DIGIT    = 7'd48;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic last_chunk;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic quot_nz;
	} sts_t;

	function automatic logic [6:0] digit_to_ascii(input logic [DIG_W-1:0] d);
		logic [6:0] c;
		if (d < UPPER_START) begin
			c = 7'(CH_LOWER + 7'(d));
		end else if (d < DIGIT_START) begin
			c = 7'(CH_UPPER + 7'(d - UPPER_START));
		end else begin
			c = 7'(CH_DIGIT + 7'(d - DIGIT_START));
		end
		return c;
	endfunction

endpackage

>>> design/b62enc_dp.sv
// ----------------------------------------------------------------------------
// b62enc_dp
// Datapath: chunked long division by 62 and a digit stack, MSD on top.
// ----------------------------------------------------------------------------
module b62enc_dp #(
	parameter int ID_BITS    = 63,
	parameter int MAX_DIGITS = 11
) (
	input  logic                clk,
	input  logic [ID_BITS-1:0]  id_value,
	input  b62enc_pkg::cmd_t    cmd,
	output b62enc_pkg::sts_t    sts,
	output logic [6:0]          char_code
);
	import b62enc_pkg::*;

	localparam int CHUNKS = (ID_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
	localparam int W      = CHUNKS * CHUNK_BITS;
	localparam int PROD_W = X_W + RECIP_W;

	logic [W-1:0]          val_q;
	logic [DIG_W-1:0]      rem_q;
	logic                  nz_q;
	logic [DIG_W-1:0]      digs_q [MAX_DIGITS];

	logic [X_W-1:0]        x;
	logic [PROD_W-1:0]     prod;
	logic [CHUNK_BITS-1:0] q;
	logic [DIG_W-1:0]      r;

	assign x    = {rem_q, val_q[W-1 -: CHUNK_BITS]};
	assign prod = PROD_W'(x) * PROD_W'(RECIP);
	assign q    = prod[DIV_SHIFT +: CHUNK_BITS];
	// x - 62q, low bits only: -62q == 2q mod 64
	assign r    = DIG_W'(x[DIG_W-1:0] + {q[DIG_W-2:0], 1'b0});

	assign sts.quot_nz = nz_q | (|q);
	assign char_code   = digit_to_ascii(digs_q[0]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= W'(id_value);
			rem_q <= '0;
			nz_q  <= 1'b0;
		end else if (cmd.step) begin
			val_q <= (val_q << CHUNK_BITS) | W'(q);
			rem_q <= cmd.last_chunk ? '0 : r;
			nz_q  <= cmd.last_chunk ? 1'b0 : (nz_q | (|q));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && cmd.last_chunk) begin
			digs_q[0] <= r;
			for (int i = 1; i < MAX_DIGITS; i++) begin
				digs_q[i] <= digs_q[i-1];
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < MAX_DIGITS - 1; i++) begin
				digs_q[i] <= digs_q[i+1];
			end
		end
	end

endmodule

>>> design/b62enc_ctrl.sv
// ----------------------------------------------------------------------------
// b62enc_ctrl
// Controller: load, per-chunk division steps, digit count, word emission.
// ----------------------------------------------------------------------------
module b62enc_ctrl #(
	parameter int ID_BITS    = 63,
	parameter int MAX_DIGITS = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             last_char,
	output b62enc_pkg::cmd_t cmd,
	input  b62enc_pkg::sts_t sts
);
	import b62enc_pkg::*;
	`include "base62_id_encoder_top_defines.svh"

	localparam int CHUNKS = (ID_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
	localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int NW     = $clog2(MAX_DIGITS + 1);

	state_t        state_q, state_n;
	logic [CW-1:0] chunk_q;
	logic [NW-1:0] count_q;
	logic          last_chunk;
	logic          more;

	assign last_chunk = (chunk_q == CW'(CHUNKS - 1));
	assign more       = sts.quot_nz && (count_q < NW'(MAX_DIGITS - 1));

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_n = ST_DIV;
			end
			ST_DIV: begin
				if (last_chunk && !more) state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready && count_q == NW'(1)) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		cmd.load       = 1'b0;
		cmd.step       = 1'b0;
		cmd.last_chunk = last_chunk;
		cmd.pop        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				cmd.pop   = out_ready;
			end
			default: ;
		endcase
	end

	assign last_char = (count_q == NW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chunk_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_n;
			if (cmd.load) begin
				chunk_q <= '0;
				count_q <= '0;
			end else if (cmd.step) begin
				chunk_q <= last_chunk ? '0 : CW'(chunk_q + 1'b1);
				if (last_chunk) count_q <= NW'(count_q + 1'b1);
			end else if (cmd.pop) begin
				count_q <= NW'(count_q - 1'b1);
			end
		end
	end

	`B62_ASSERT_NOW(a_emit_count, out_valid, count_q != '0, "word shown with empty digit stack")
	`B62_ASSERT_NOW(a_one_side, in_ready, !out_valid, "input taken while words pending")
	`B62_ASSERT_NEXT(a_load_div, in_valid && in_ready, state_q == ST_DIV && chunk_q == '0,
		"accepted id did not start division")
	`B62_ASSERT_NOW(a_count_cap, state_q == ST_EMIT, count_q <= NW'(MAX_DIGITS),
		"digit count beyond stack depth")

endmodule

>>> design/base62_id_encoder_top.sv
// An id of n base-62 digits is divided in 21-bit chunks, with one 27x28 reciprocal
// multiply per cycle; then its first word appears.
// Words follow one per cycle while out_ready is high; the next id is taken in
// the cycle after the last word is accepted.
// Reset (arst_n low, asynchronous) returns the controller to idle, ready for input.
// ----------------------------------------------------------------------------
// base62_id_encoder_top
// Encodes a non-negative id as base-62 ASCII, most significant character first.
// ----------------------------------------------------------------------------
module base62_id_encoder_top #(
	parameter int ID_BITS    = 63,
	parameter int MAX_DIGITS = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ID_BITS-1:0] id_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [6:0]         char_code,
	output logic               last_char
);
	import b62enc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	b62enc_ctrl #(
		.ID_BITS    (ID_BITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.last_char (last_char),
		.cmd       (cmd),
		.sts       (sts)
	);

	b62enc_dp #(
		.ID_BITS    (ID_BITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk       (clk),
		.id_value  (id_value),
		.cmd       (cmd),
		.sts       (sts),
		.char_code (char_code)
	);

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for base62_id_encoder_top. A short table of ids (zero,
// each character range edge, digit-count boundaries, the largest id) is sent
// first. Random ids follow, many of them near powers of 62. Each character
// word is checked against the table text or else a base-62 digit predictor
// in the bench. Both sides idle and stall at random, with calm phases.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int ID_W        = 63;
	localparam int MAX_DIG     = 11;
	localparam int RADIX       = 62;
	localparam int UPPER_FIRST = 26;
	localparam int NUM_FIRST   = 52;
	localparam int ASCII_LA    = 97;
	localparam int ASCII_UA    = 65;
	localparam int ASCII_ZERO  = 48;
	localparam int RAND_IDS    = 500;
	localparam int PHASES      = 5;
	localparam int DRAIN_WAIT  = 60;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int MAX_REPORTS = 10;
	localparam int DIR_N       = 17;

	typedef struct {
		logic [6:0] code;
		logic       last;
	} b62_char_t;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [ID_W-1:0] id_value;
	logic            out_valid;
	logic            out_ready;
	logic [6:0]      char_code;
	logic            last_char;

	b62_char_t exp_chars[$];
	b62_char_t got_want;
	int        bad_words;
	int        cycles;
	int        stall_left;
	bit        tx_calm;
	bit        rx_calm;

	// empty text: the predictor supplies the characters
	logic [ID_W-1:0] dir_ids [DIR_N] = '{
		63'd0, 63'd1, 63'd25, 63'd26, 63'd51, 63'd52, 63'd61, 63'd62,
		63'd3843, 63'd3844,
		63'(64'd62 ** 10 - 64'd1),
		63'(64'd62 ** 10),
		{ID_W{1'b1}},
		63'(64'h5555_5555_5555_5555),
		63'(64'h2AAA_AAAA_AAAA_AAAA),
		63'd1234567890,
		63'(64'h4000_0000_0000_0000)
	};
	string dir_text [DIR_N] = '{
		"a", "b", "z", "A", "Z", "0", "9", "ba",
		"99", "baa",
		"9999999999",
		"baaaaaaaaaa",
		"", "", "", "", ""
	};

	base62_id_encoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.id_value  (id_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.last_char (last_char)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [6:0] digit_char(input int d);
		if (d < UPPER_FIRST)
			return 7'(ASCII_LA + d);
		else if (d < NUM_FIRST)
			return 7'(ASCII_UA + d - UPPER_FIRST);
		return 7'(ASCII_ZERO + d - NUM_FIRST);
	endfunction

	// digits come out least significant first, are queued most significant first
	task automatic predict_b62(input logic [ID_W-1:0] id);
		logic [ID_W-1:0] rest;
		int              digs [MAX_DIG];
		int              n;
		b62_char_t       c;
		rest = id;
		n = 0;
		do begin
			digs[n] = int'(rest % RADIX);
			rest = rest / RADIX;
			n++;
		end while (rest != 0 && n < MAX_DIG);
		for (int k = 0; k < n; k++) begin
			c.code = digit_char(digs[n-1-k]);
			c.last = (k == n - 1);
			exp_chars.push_back(c);
		end
	endtask

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [ID_W-1:0] rand_id();
		logic [63:0] full;
		logic [63:0] p;
		int          mode;
		full = {$urandom, $urandom};
		mode = $urandom_range(0, 9);
		if (mode < 4) begin
			return ID_W'(full[62:0] >> $urandom_range(0, 62));
		end else if (mode < 7) begin
			return full[62:0];
		end else if (mode < 9) begin
			p = 64'd1;
			repeat ($urandom_range(1, 10)) p = p * RADIX;
			return ID_W'(p + 64'($urandom_range(0, 2)) - 64'd1);
		end else if (full[63]) begin
			return {ID_W{1'b1}} - ID_W'($urandom_range(0, 3));
		end
		return ID_W'($urandom_range(0, 3));
	endfunction

	task automatic send_id(input logic [ID_W-1:0] id, input string text);
		int        gap;
		b62_char_t c;
		gap = tx_calm ? 0 : rand_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		id_value <= id;
		do @(posedge clk); while (!in_ready);
		if (text.len() == 0) begin
			predict_b62(id);
		end else begin
			for (int i = 0; i < text.len(); i++) begin
				c.code = 7'(text[i]);
				c.last = (i == text.len() - 1);
				exp_chars.push_back(c);
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (!rx_calm)
				stall_left = rand_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (exp_chars.size() == 0) begin
				bad_words++;
				if (bad_words <= MAX_REPORTS)
					$display("unexpected word: char_code=%0d last_char=%0b",
						char_code, last_char);
			end else begin
				got_want = exp_chars.pop_front();
				if (char_code !== got_want.code || last_char !== got_want.last) begin
					bad_words++;
					if (bad_words <= MAX_REPORTS)
						$display("word mismatch: expected %0d/%0b, got %0d/%0b",
							got_want.code, got_want.last, char_code, last_char);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		bad_words  = 0;
		cycles     = 0;
		stall_left = 0;
		tx_calm    = 1'b0;
		rx_calm    = 1'b0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		id_value  <= '0;
		out_ready <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_id(dir_ids[i], dir_text[i]);

		for (int ph = 0; ph < PHASES; ph++) begin
			tx_calm = (ph % 2 == 1);
			rx_calm = (ph == 3);
			for (int i = 0; i < RAND_IDS / PHASES; i++)
				send_id(rand_id(), "");
		end
		in_valid <= 1'b0;

		rx_calm = 1'b1;
		while (exp_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (bad_words == 0 && exp_chars.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

>>> base62_id_encoder_top.f
+incdir+design
design/b62enc_pkg.sv
design/b62enc_dp.sv
design/b62enc_ctrl.sv
design/base62_id_encoder_top.sv
test/tb_top.sv
